// ===== hdl/wptc_pkg.sv =====
// ----------------------------------------------------------------------------
// wptc_pkg
// Shared types, codes and arithmetic helpers of the path-tracking controller.
// ----------------------------------------------------------------------------
package wptc_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned CORDIC_STEPS   = 20;
  localparam int unsigned SQRT_STEPS     = 32;
  localparam int unsigned CORDIC_W       = 58;

  localparam logic signed [31:0] PI_Q29          = 32'sd1686629713;
  localparam logic signed [18:0] RAD_PER_BAM_Q15 = 19'sd205887;
  localparam logic signed [15:0] Q14_ONE         = 16'sd16384;

  // item commands
  localparam logic [2:0] CMD_NEW_PATH = 3'd0;
  localparam logic [2:0] CMD_APPEND   = 3'd1;
  localparam logic [2:0] CMD_POSE     = 3'd2;
  localparam logic [2:0] CMD_TICK     = 3'd3;
  localparam logic [2:0] CMD_RESET    = 3'd4;

  // register indexes
  localparam logic [2:0] REG_GAIN_DIST    = 3'd0;
  localparam logic [2:0] REG_GAIN_BEARING = 3'd1;
  localparam logic [2:0] REG_GAIN_FINAL   = 3'd2;
  localparam logic [2:0] REG_SEARCH_WIN   = 3'd3;
  localparam logic [2:0] REG_LOOKAHEAD    = 3'd4;
  localparam logic [2:0] REG_GOAL_X       = 3'd5;
  localparam logic [2:0] REG_GOAL_Y       = 3'd6;
  localparam logic [2:0] REG_GOAL_RADIUS  = 3'd7;

  // drive direction codes
  localparam logic [1:0] DS_NONE = 2'b00;
  localparam logic [1:0] DS_FWD  = 2'b01;
  localparam logic [1:0] DS_REV  = 2'b11;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] steer_cmd;
    logic signed [15:0] speed_cmd;
    logic               tracking;
  } out_item_t;

  typedef struct packed {
    logic       accept;
    logic       goal_ld;
    logic       goal_cmp;
    logic       srch_init;
    logic       srch_run;
    logic       look_addr;
    logic       look_data;
    logic       c_init;
    logic       c_step;
    logic       r_init;
    logic       r_step;
    logic       ang;
    logic       mul;
    logic       sum;
    logic       mul2;
    logic       emit;
    logic       emit_z;
    logic [4:0] step;
  } ctl_t;

  typedef struct packed {
    logic trk_ok;
    logic srch_done;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] abs_cap(input logic signed [32:0] d);
    logic [32:0] a;
    a = d[32] ? 33'(-d) : 33'(d);
    return a[32] ? 32'hFFFF_FFFF : a[31:0];
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic logic signed [15:0] clamp_q14(input logic signed [47:0] v);
    logic signed [47:0] hi;
    hi = 48'(Q14_ONE);
    if (v > hi) return Q14_ONE;
    if (v < -hi) return -Q14_ONE;
    return v[15:0];
  endfunction

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/wptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// wptc_ctrl
// Sequencer of the controller: accepts words and steps a tick through the
// datapath.
// ----------------------------------------------------------------------------
module wptc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        in_cmd_i,
  output logic              in_stall_o,
  input  wptc_pkg::sts_t    sts_i,
  output wptc_pkg::ctl_t    ctl_o
);

  typedef enum logic [17:0] {
    S_IDLE      = 18'h00001,
    S_GOAL_LD   = 18'h00002,
    S_GOAL_SQ   = 18'h00004,
    S_GOAL_SUM  = 18'h00008,
    S_GOAL_CMP  = 18'h00010,
    S_SRCH_INIT = 18'h00020,
    S_SRCH      = 18'h00040,
    S_LOOK_ADDR = 18'h00080,
    S_LOOK_DATA = 18'h00100,
    S_C_INIT    = 18'h00200,
    S_C_STEP    = 18'h00400,
    S_R_INIT    = 18'h00800,
    S_R_STEP    = 18'h01000,
    S_ANG       = 18'h02000,
    S_MUL       = 18'h04000,
    S_SUM       = 18'h08000,
    S_MUL2      = 18'h10000,
    S_EMIT      = 18'h20000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       emit_z_q, emit_z_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    emit_z_d = emit_z_q;
    ctl_o    = '0;
    ctl_o.step = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        ctl_o.accept = in_valid_i;
        if (in_valid_i && in_cmd_i == wptc_pkg::CMD_TICK) begin
          state_d = S_GOAL_LD;
        end
      end
      S_GOAL_LD: begin
        ctl_o.goal_ld = 1'b1;
        state_d = S_GOAL_SQ;
      end
      S_GOAL_SQ:  state_d = S_GOAL_SUM;
      S_GOAL_SUM: state_d = S_GOAL_CMP;
      S_GOAL_CMP: begin
        ctl_o.goal_cmp = 1'b1;
        state_d = S_SRCH_INIT;
      end
      S_SRCH_INIT: begin
        if (sts_i.trk_ok) begin
          ctl_o.srch_init = 1'b1;
          state_d = S_SRCH;
        end else begin
          emit_z_d = 1'b1;
          state_d  = S_EMIT;
        end
      end
      S_SRCH: begin
        ctl_o.srch_run = 1'b1;
        if (sts_i.srch_done) state_d = S_LOOK_ADDR;
      end
      S_LOOK_ADDR: begin
        ctl_o.look_addr = 1'b1;
        state_d = S_LOOK_DATA;
      end
      S_LOOK_DATA: begin
        ctl_o.look_data = 1'b1;
        state_d = S_C_INIT;
      end
      S_C_INIT: begin
        ctl_o.c_init = 1'b1;
        cnt_d   = '0;
        state_d = S_C_STEP;
      end
      S_C_STEP: begin
        ctl_o.c_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(wptc_pkg::CORDIC_STEPS - 1)) state_d = S_R_INIT;
      end
      S_R_INIT: begin
        ctl_o.r_init = 1'b1;
        cnt_d   = '0;
        state_d = S_R_STEP;
      end
      S_R_STEP: begin
        ctl_o.r_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(wptc_pkg::SQRT_STEPS - 1)) state_d = S_ANG;
      end
      S_ANG: begin
        ctl_o.ang = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        ctl_o.mul = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        ctl_o.sum = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        ctl_o.mul2 = 1'b1;
        emit_z_d = 1'b0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          ctl_o.emit   = !emit_z_q;
          ctl_o.emit_z = emit_z_q;
          emit_z_d     = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      emit_z_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      emit_z_q <= emit_z_d;
    end
  end

endmodule

// ===== hdl/wptc_dpath.sv =====
// ----------------------------------------------------------------------------
// wptc_dpath
// Datapath: registers, path memory, search pipeline, CORDIC, square root
// and output scaling.
// ----------------------------------------------------------------------------
module wptc_dpath #(
  parameter int unsigned MAX_POINTS = wptc_pkg::MAX_POINTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  wptc_pkg::in_item_t  in_item_i,
  input  wptc_pkg::ctl_t      ctl_i,
  output wptc_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wptc_pkg::out_item_t out_item_o
);

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned EW  = ((AW > 11) ? AW : 11) + 1;
  localparam int unsigned LW  = ((AW > 10) ? AW : 10) + 1;
  localparam int unsigned XW  = wptc_pkg::CORDIC_W;

  // configuration
  logic signed [15:0] gd_q, gb_q, gf_q;
  logic [10:0]        sw_q;
  logic [9:0]         la_q;
  logic signed [31:0] gx_q, gy_q;
  logic [30:0]        gr_q;

  // tracking state
  logic [CW-1:0]      count_q;
  logic [AW-1:0]      ni_q;
  logic               have_path_q, have_pose_q;
  logic signed [31:0] pose_x_q, pose_y_q;
  logic signed [15:0] pose_h_q;
  logic [1:0]         ds_q;

  // path memory
  logic [79:0]   mem [MAX_POINTS];
  logic [79:0]   rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;

  // shared squaring
  logic [31:0] ax_q, ay_q;
  logic [63:0] sqx_q, sqy_q, sxy_q;
  logic [61:0] gr2_q;

  // search pipeline
  logic [EW-1:0]      end_q, addr_q;
  logic               issue;
  logic               v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [AW-1:0]      idx1_q, idx2_q, idx3_q, idx4_q, idx5_q;
  logic signed [34:0] dhm_q;
  logic [35:0]        sqh_q, sqh3_q;
  logic [63:0]        cost_q, best_q;
  logic               found_q;

  // target, CORDIC, square root
  logic signed [32:0]   dx_q, dy_q;
  logic signed [15:0]   th_q;
  logic                 zero_q;
  logic signed [XW-1:0] cx_q, cy_q;
  logic [31:0]          ang_q;
  logic [63:0]          sv_q, sr_q, sb_q;

  // output scaling
  logic signed [15:0] alpha_q, beta_q;
  logic signed [31:0] pa_q, pb_q;
  logic signed [48:0] ps_q;
  logic signed [32:0] sum_q;
  logic signed [49:0] spd_q;
  logic signed [64:0] st_q;

  logic                out_valid_q;
  wptc_pkg::out_item_t out_q;

  // ---- combinational helpers ----
  logic               accept_new, accept_app;
  logic               goal_hit;
  logic [EW-1:0]      end_sum;
  logic [LW-1:0]      look_sum, look_idx;
  logic signed [15:0] hd;
  logic signed [34:0] hd_ext;
  logic signed [34:0] dh;
  logic [34:0]        dh_abs;
  logic signed [31:0] rd_x, rd_y;
  logic signed [15:0] rd_h;
  logic signed [32:0] sdx, sdy;
  logic signed [XW-1:0] shx, shy, cx0, cy0;
  logic [64:0]        sq_t;
  logic [31:0]        ang_r;
  logic signed [15:0] bear, alpha_d, beta_d;
  logic               cur_fwd;
  logic signed [48:0] rho_ext;
  logic signed [64:0] st_sh;
  logic signed [49:0] spd_sh;
  logic               out_free;

  assign rd_x = rd_q[79:48];
  assign rd_y = rd_q[47:16];
  assign rd_h = rd_q[15:0];

  assign accept_new = ctl_i.accept && in_item_i.cmd == wptc_pkg::CMD_NEW_PATH;
  assign accept_app = ctl_i.accept && in_item_i.cmd == wptc_pkg::CMD_APPEND && have_path_q
                      && (count_q < CW'(MAX_POINTS));
  assign goal_hit   = have_pose_q && ({2'b0, sxy_q} < {4'b0, gr2_q});

  assign end_sum  = EW'(sw_q) + EW'(ni_q);
  assign look_sum = LW'(ni_q) + LW'(la_q);
  assign look_idx = (look_sum >= LW'(count_q)) ? LW'(count_q) - LW'(1) : look_sum;
  assign issue    = ctl_i.srch_run && (addr_q < end_q);

  assign mem_we    = accept_new || accept_app;
  assign mem_waddr = accept_new ? '0 : count_q[AW-1:0];
  assign mem_re    = issue || ctl_i.look_addr;
  assign mem_raddr = ctl_i.look_addr ? look_idx[AW-1:0] : addr_q[AW-1:0];

  assign hd     = rd_h - pose_h_q;
  assign hd_ext = 35'(hd);
  assign dh     = dhm_q >>> 15;
  assign dh_abs = dh[34] ? 35'(-dh) : 35'(dh);

  assign sdx = 33'(rd_x) - 33'(pose_x_q);
  assign sdy = 33'(rd_y) - 33'(pose_y_q);

  assign shx  = cx_q >>> ctl_i.step;
  assign shy  = cy_q >>> ctl_i.step;
  assign cx0  = XW'(dx_q) <<< 20;
  assign cy0  = XW'(dy_q) <<< 20;
  assign sq_t = {1'b0, sr_q} + {1'b0, sb_q};

  assign ang_r   = ang_q + 32'h0000_8000;
  assign bear    = zero_q ? 16'sd0 : ang_r[31:16];
  assign alpha_d = bear - pose_h_q;
  assign beta_d  = th_q - pose_h_q - alpha_d;
  assign cur_fwd = (alpha_d > -wptc_pkg::Q14_ONE) && (alpha_d <= wptc_pkg::Q14_ONE);
  assign rho_ext = {17'b0, sr_q[31:0]};

  assign st_sh  = st_q >>> 38;
  assign spd_sh = spd_q >>> 10;

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.trk_ok    = have_path_q && have_pose_q;
  assign sts_o.srch_done = !(addr_q < end_q) && !v1_q && !v2_q && !v3_q && !v4_q && !v5_q;
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---- path memory ----
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= {in_item_i.pos_x, in_item_i.pos_y, in_item_i.heading};
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  // ---- configuration and tracking state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gd_q        <= 16'sd256;
      gb_q        <= 16'sd256;
      gf_q        <= 16'sd0;
      sw_q        <= 11'd10;
      la_q        <= 10'd10;
      gx_q        <= '0;
      gy_q        <= '0;
      gr_q        <= '0;
      count_q     <= '0;
      ni_q        <= '0;
      have_path_q <= 1'b0;
      have_pose_q <= 1'b0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      pose_h_q    <= '0;
      ds_q        <= wptc_pkg::DS_NONE;
      found_q     <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      end_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wptc_pkg::REG_GAIN_DIST:    gd_q <= cfg_wdata_i[15:0];
          wptc_pkg::REG_GAIN_BEARING: gb_q <= cfg_wdata_i[15:0];
          wptc_pkg::REG_GAIN_FINAL:   gf_q <= cfg_wdata_i[15:0];
          wptc_pkg::REG_SEARCH_WIN:   sw_q <= cfg_wdata_i[10:0];
          wptc_pkg::REG_LOOKAHEAD:    la_q <= cfg_wdata_i[9:0];
          wptc_pkg::REG_GOAL_X:       gx_q <= cfg_wdata_i;
          wptc_pkg::REG_GOAL_Y:       gy_q <= cfg_wdata_i;
          wptc_pkg::REG_GOAL_RADIUS:  gr_q <= cfg_wdata_i[30:0];
          default: ;
        endcase
      end

      if (ctl_i.accept) begin
        unique case (in_item_i.cmd)
          wptc_pkg::CMD_NEW_PATH: begin
            count_q     <= CW'(1);
            have_path_q <= 1'b1;
            ni_q        <= '0;
          end
          wptc_pkg::CMD_APPEND: begin
            if (accept_app) count_q <= count_q + CW'(1);
          end
          wptc_pkg::CMD_POSE: begin
            pose_x_q    <= in_item_i.pos_x;
            pose_y_q    <= in_item_i.pos_y;
            pose_h_q    <= in_item_i.heading;
            have_pose_q <= 1'b1;
          end
          wptc_pkg::CMD_RESET: begin
            have_path_q <= 1'b0;
            have_pose_q <= 1'b0;
            count_q     <= '0;
            ds_q        <= wptc_pkg::DS_NONE;
          end
          default: ;
        endcase
      end

      // goal reached: drop path, pose and direction
      if (ctl_i.goal_cmp && goal_hit) begin
        have_path_q <= 1'b0;
        have_pose_q <= 1'b0;
        count_q     <= '0;
        ds_q        <= wptc_pkg::DS_NONE;
      end

      if (ctl_i.srch_init) begin
        end_q   <= (end_sum >= EW'(count_q)) ? EW'(count_q) : end_sum;
        addr_q  <= EW'(ni_q) + EW'(1);
        found_q <= 1'b0;
      end else if (issue) begin
        addr_q <= addr_q + EW'(1);
      end

      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;

      // first candidate always wins, later ones only when strictly closer
      if (v5_q && (!found_q || cost_q < best_q)) begin
        found_q <= 1'b1;
        ni_q    <= idx5_q;
      end

      if (ctl_i.ang && ds_q == wptc_pkg::DS_NONE) begin
        ds_q <= cur_fwd ? wptc_pkg::DS_FWD : wptc_pkg::DS_REV;
      end

      if (ctl_i.emit || ctl_i.emit_z) out_valid_q <= 1'b1;
      else if (!out_stall_i)           out_valid_q <= 1'b0;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (ctl_i.goal_ld) begin
      ax_q  <= wptc_pkg::abs_cap(33'(gx_q) - 33'(pose_x_q));
      ay_q  <= wptc_pkg::abs_cap(33'(gy_q) - 33'(pose_y_q));
      gr2_q <= 62'(gr_q) * 62'(gr_q);
    end else if (v1_q) begin
      ax_q <= wptc_pkg::abs_cap(sdx);
      ay_q <= wptc_pkg::abs_cap(sdy);
    end else if (ctl_i.look_data) begin
      ax_q <= wptc_pkg::abs_cap(sdx);
      ay_q <= wptc_pkg::abs_cap(sdy);
    end

    sqx_q <= 64'(ax_q) * 64'(ax_q);
    sqy_q <= 64'(ay_q) * 64'(ay_q);
    sxy_q <= wptc_pkg::sat_add64(sqx_q, sqy_q);

    idx1_q <= addr_q[AW-1:0];
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
    idx5_q <= idx4_q;

    dhm_q  <= hd_ext * 35'(wptc_pkg::RAD_PER_BAM_Q15);
    sqh_q  <= 36'(dh_abs[17:0]) * 36'(dh_abs[17:0]);
    sqh3_q <= sqh_q;
    cost_q <= wptc_pkg::sat_add64(sxy_q, 64'(sqh3_q));
    if (v5_q && (!found_q || cost_q < best_q)) best_q <= cost_q;

    if (ctl_i.look_data) begin
      dx_q   <= sdx;
      dy_q   <= sdy;
      th_q   <= rd_h;
      zero_q <= (sdx == '0) && (sdy == '0);
    end

    if (ctl_i.c_init) begin
      if (dx_q[32]) begin
        cx_q  <= -cx0;
        cy_q  <= -cy0;
        ang_q <= 32'h8000_0000;
      end else begin
        cx_q  <= cx0;
        cy_q  <= cy0;
        ang_q <= '0;
      end
    end else if (ctl_i.c_step) begin
      if (!cy_q[XW-1] && cy_q != '0) begin
        cx_q  <= cx_q + shy;
        cy_q  <= cy_q - shx;
        ang_q <= ang_q + wptc_pkg::atan_entry(ctl_i.step);
      end else begin
        cx_q  <= cx_q - shy;
        cy_q  <= cy_q + shx;
        ang_q <= ang_q - wptc_pkg::atan_entry(ctl_i.step);
      end
    end

    if (ctl_i.r_init) begin
      sv_q <= sxy_q;
      sr_q <= '0;
      sb_q <= 64'h4000_0000_0000_0000;
    end else if (ctl_i.r_step) begin
      if ({1'b0, sv_q} >= sq_t) begin
        sv_q <= sv_q - sq_t[63:0];
        sr_q <= (sr_q >> 1) + sb_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sb_q <= sb_q >> 2;
    end

    if (ctl_i.ang) begin
      alpha_q <= alpha_d;
      beta_q  <= beta_d;
    end
    if (ctl_i.mul) begin
      pa_q <= 32'(gb_q) * 32'(alpha_q);
      pb_q <= 32'(gf_q) * 32'(beta_q);
      ps_q <= 49'(gd_q) * rho_ext;
    end
    if (ctl_i.sum) begin
      sum_q <= 33'(pa_q) + 33'(pb_q);
      spd_q <= (ds_q == wptc_pkg::DS_REV) ? -50'(ps_q) : 50'(ps_q);
    end
    if (ctl_i.mul2) begin
      st_q <= 65'(sum_q) * 65'(wptc_pkg::PI_Q29);
    end

    if (ctl_i.emit) begin
      out_q.steer_cmd <= wptc_pkg::clamp_q14(st_sh[47:0]);
      out_q.speed_cmd <= wptc_pkg::clamp_q14(spd_sh[47:0]);
      out_q.tracking  <= 1'b1;
    end else if (ctl_i.emit_z) begin
      out_q.steer_cmd <= '0;
      out_q.speed_cmd <= '0;
      out_q.tracking  <= 1'b0;
    end
  end

endmodule

// ===== hdl/windowed_path_tracking_controller.sv =====
// ----------------------------------------------------------------------------
// windowed_path_tracking_controller
// Windowed polar-coordinate path-tracking controller, top level.
// ----------------------------------------------------------------------------
// Usage: input words carry a command and a point or pose (cmd, pos_x, pos_y,
// heading). New-path, append, pose and reset words return nothing; the block
// takes the next word in the following cycle. A tick returns one word
// (steer_cmd, speed_cmd, tracking) on the output channel. With path and pose
// present the tick runs the goal test, a search over the path points in the
// window (one memory read per cycle plus a five-stage cost pipeline), a
// 20-step CORDIC, a 32-step square root and the output multiplies. A tick
// without path or pose, or one that reaches the goal, answers with a zero
// word. While a tick runs, in_stall_o stays high. A stalled output holds its
// word and the block keeps taking words; a tick that finishes while that word
// still waits holds until it is taken. Registers are written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must do so only while the block
// is idle, the block itself does not enforce it. Reset clears the path, pose
// and drive direction and loads the register defaults; path memory contents
// are not cleared.
// ----------------------------------------------------------------------------
module windowed_path_tracking_controller #(
  parameter int unsigned MAX_POINTS = wptc_pkg::MAX_POINTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wptc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wptc_pkg::out_item_t out_item_o
);

  wptc_pkg::ctl_t ctl;
  wptc_pkg::sts_t sts;

  wptc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_item_i.cmd),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  wptc_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
